FILE: src/vnu_pkg.sv
package vnu_pkg;

    localparam int unsigned COMP_W = 32;
    localparam int unsigned ROOT_W = 32;
    localparam int unsigned QUO_W  = 17;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_POINT = 2'd1,
        STATUS_ZERO  = 2'd2
    } status_t;

    // Payload carried alongside the length and quotient pipelines.
    typedef struct packed {
        logic [2:0][COMP_W-1:0] comp;    // original components
        logic [2:0][COMP_W-1:0] mag;     // absolute values
        logic [2:0]             neg;     // component sign
        logic                   tag;
        status_t                status;
    } meta_t;

    typedef struct packed {
        logic [63:0] sum;
        meta_t       meta;
    } work_t;

endpackage

FILE: src/vnu_front.sv
module vnu_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [95:0]           in_data,
    input  logic                  in_tag,
    output logic                  out_valid,
    output vnu_pkg::work_t        out_work
);

    logic           a_valid_reg;
    logic [95:0]    a_data_reg;
    logic           a_tag_reg;
    logic           b_valid_reg;
    vnu_pkg::meta_t b_meta_reg;
    logic [2:0][63:0] b_sq_reg;
    logic           c_valid_reg;
    vnu_pkg::work_t c_work_reg;

    vnu_pkg::meta_t a_meta;
    vnu_pkg::meta_t c_meta_next;
    logic [65:0]    sum_next;

    always_comb begin
        a_meta = '0;
        for (int k = 0; k < 3; k++) begin
            a_meta.comp[k] = a_data_reg[k*32 +: 32];
            a_meta.neg[k]  = a_data_reg[k*32 + 31];
            a_meta.mag[k]  = a_meta.neg[k] ? (32'd0 - a_meta.comp[k]) : a_meta.comp[k];
        end
        a_meta.tag    = a_tag_reg;
        a_meta.status = a_tag_reg ? vnu_pkg::STATUS_POINT : vnu_pkg::STATUS_OK;
    end

    assign sum_next = {2'b0, b_sq_reg[0]} + {2'b0, b_sq_reg[1]} + {2'b0, b_sq_reg[2]};

    // Mark a vector with zero length.
    always_comb begin
        c_meta_next = b_meta_reg;
        if (b_meta_reg.status == vnu_pkg::STATUS_OK && sum_next == 66'd0) begin
            c_meta_next.status = vnu_pkg::STATUS_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_data_reg <= in_data;
            a_tag_reg  <= in_tag;
            b_meta_reg <= a_meta;
            for (int k = 0; k < 3; k++) begin
                b_sq_reg[k] <= a_meta.mag[k] * a_meta.mag[k];
            end
            c_work_reg.sum  <= sum_next[63:0];
            c_work_reg.meta <= c_meta_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_work  = c_work_reg;

endmodule

FILE: src/vnu_fifo.sv
module vnu_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  vnu_pkg::work_t push_data,
    input  logic           pop,
    output vnu_pkg::work_t head,
    output logic           empty,
    output logic           full
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    vnu_pkg::work_t      mem_reg [DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [PW:0]         count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/vnu_sqrt.sv
module vnu_sqrt (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  vnu_pkg::work_t in_work,
    output logic           out_valid,
    output logic [31:0]    out_root,
    output vnu_pkg::meta_t out_meta
);

    localparam int unsigned N = vnu_pkg::ROOT_W;

    logic           vld   [N+1];
    logic [33:0]    rem   [N+1];
    logic [31:0]    root  [N+1];
    logic [63:0]    rad   [N+1];
    vnu_pkg::meta_t meta  [N+1];

    assign vld[0]  = in_valid;
    assign rem[0]  = '0;
    assign root[0] = '0;
    assign rad[0]  = in_work.sum;
    assign meta[0] = in_work.meta;

    // One root bit per stage, restoring.
    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [35:0] sh;
        logic [35:0] tr;
        logic        ge;
        assign sh = {rem[i], rad[i][63:62]};
        assign tr = {2'b0, root[i], 2'b01};
        assign ge = (sh >= tr);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld[i+1] <= 1'b0;
            end else if (en) begin
                vld[i+1] <= vld[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem[i+1]  <= ge ? 34'(sh - tr) : sh[33:0];
                root[i+1] <= {root[i][30:0], ge};
                rad[i+1]  <= {rad[i][61:0], 2'b00};
                meta[i+1] <= meta[i];
            end
        end
    end

    assign out_valid = vld[N];
    assign out_root  = root[N];
    assign out_meta  = meta[N];

endmodule

FILE: src/vnu_div.sv
module vnu_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [31:0]    in_len,
    input  vnu_pkg::meta_t in_meta,
    output logic           out_valid,
    output logic [31:0]    out_len,
    output logic [2:0][vnu_pkg::QUO_W-1:0] out_quo,
    output vnu_pkg::meta_t out_meta
);

    localparam int unsigned N = vnu_pkg::QUO_W;

    logic             vld  [N+1];
    logic [31:0]      len  [N+1];
    logic [2:0][31:0] rem  [N+1];
    logic [2:0][N-1:0] quo [N+1];
    vnu_pkg::meta_t   meta [N+1];

    assign vld[0]  = in_valid;
    assign len[0]  = in_len;
    assign meta[0] = in_meta;
    // The quotient fits 17 bits, so the top 31 dividend bits start below the divisor.
    for (genvar k = 0; k < 3; k++) begin : g_init
        assign rem[0][k] = {1'b0, in_meta.mag[k][31:1]};
        assign quo[0][k] = '0;
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [2:0][31:0] rem_n;
        logic [2:0]       bit_n;
        always_comb begin
            for (int k = 0; k < 3; k++) begin
                logic [32:0] t;
                t = {rem[i][k], (i == 0) ? meta[i].mag[k][0] : 1'b0};
                bit_n[k] = (t >= {1'b0, len[i]});
                rem_n[k] = bit_n[k] ? 32'(t - {1'b0, len[i]}) : t[31:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld[i+1] <= 1'b0;
            end else if (en) begin
                vld[i+1] <= vld[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                len[i+1]  <= len[i];
                meta[i+1] <= meta[i];
                for (int k = 0; k < 3; k++) begin
                    rem[i+1][k] <= rem_n[k];
                    quo[i+1][k] <= {quo[i][k][N-2:0], bit_n[k]};
                end
            end
        end
    end

    assign out_valid = vld[N];
    assign out_len   = len[N];
    assign out_quo   = quo[N];
    assign out_meta  = meta[N];

endmodule

FILE: src/vector3_normalize_unit.sv
// Channel  | data (low bit first)                                  | user
// s_       | coord_x, coord_y, coord_z                             | kind_tag
// m_       | unit_x, unit_y, unit_z, magnitude, status, 6 zero bits | out_tag
//
// One word per cycle sustained while m_tready stays high. The path is 3 front
// stages, one queue slot, 32 root stages (one root bit each), 17 quotient
// stages and the output register. The front stalls only when the queue is full;
// the back advances whenever the output register is empty or taken. Synchronous
// active-low reset clears all valid bits and the queue.
module vector3_normalize_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // coord_x, coord_y, coord_z
    input  logic         s_tuser,   // kind_tag
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // unit_x, unit_y, unit_z, magnitude, status, pad
    output logic         m_tuser    // out_tag
);

    logic           front_en;
    logic           front_valid;
    vnu_pkg::work_t front_work;
    logic           q_empty;
    logic           q_full;
    logic           q_push;
    logic           q_pop;
    vnu_pkg::work_t q_head;
    logic           back_en;
    logic           sq_valid;
    logic [31:0]    sq_root;
    vnu_pkg::meta_t sq_meta;
    logic           dv_valid;
    logic [31:0]    dv_len;
    logic [2:0][vnu_pkg::QUO_W-1:0] dv_quo;
    vnu_pkg::meta_t dv_meta;

    logic           out_valid_reg;
    logic [135:0]   out_data_reg;
    logic           out_tag_reg;
    logic [135:0]   out_data_next;

    // Front advances while the queue has room.
    assign front_en = !q_full;
    assign s_tready = front_en;
    assign q_push   = front_en && front_valid;

    // Back advances while the output register is free or being drained.
    assign back_en  = !out_valid_reg || m_tready;
    assign q_pop    = back_en && !q_empty;

    vnu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (front_en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .in_tag    (s_tuser),
        .out_valid (front_valid),
        .out_work  (front_work)
    );

    vnu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (front_work),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    vnu_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (back_en),
        .in_valid  (!q_empty),
        .in_work   (q_head),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_meta  (sq_meta)
    );

    vnu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (back_en),
        .in_valid  (sq_valid),
        .in_len    (sq_root),
        .in_meta   (sq_meta),
        .out_valid (dv_valid),
        .out_len   (dv_len),
        .out_quo   (dv_quo),
        .out_meta  (dv_meta)
    );

    // Apply signs on success; pass the input through on point or zero length.
    always_comb begin
        logic [31:0] q;
        out_data_next = '0;
        for (int k = 0; k < 3; k++) begin
            q = {15'd0, dv_quo[k]};
            if (dv_meta.status == vnu_pkg::STATUS_OK) begin
                out_data_next[k*32 +: 32] = dv_meta.neg[k] ? (32'd0 - q) : q;
            end else begin
                out_data_next[k*32 +: 32] = dv_meta.comp[k];
            end
        end
        out_data_next[127:96]  = (dv_meta.status == vnu_pkg::STATUS_OK) ? dv_len : 32'd0;
        out_data_next[129:128] = dv_meta.status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (back_en) begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (back_en) begin
            out_data_reg <= out_data_next;
            out_tag_reg  <= (dv_meta.status == vnu_pkg::STATUS_OK) ? 1'b0 : dv_meta.tag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_tag_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_ok_has_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[129:128] == vnu_pkg::STATUS_OK) |->
            (m_tdata[127:96] != 32'd0 && !m_tuser))
        else $error("successful word without length or with tag set");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[129:128] != 2'd3))
        else $error("undefined status code");

    a_point_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[129:128] == vnu_pkg::STATUS_POINT) |->
            (m_tuser && m_tdata[127:96] == 32'd0))
        else $error("point word lost its tag or has a length");
`endif

endmodule
